@@ rtl/neighbor_weighted_row_sum_unit_defines.svh @@
// Assertion macros for the neighbor weighted row sum unit.
`ifndef NEIGHBOR_WEIGHTED_ROW_SUM_UNIT_DEFINES_SVH
`define NEIGHBOR_WEIGHTED_ROW_SUM_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define NWRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define NWRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/nwrs_pkg.sv @@
// Shared types and constants of the neighbor weighted row sum unit.
package nwrs_pkg;

    localparam int ITEM_COUNT_DEF     = 64;
    localparam int NEIGHBOR_SLOTS_DEF = 8;
    localparam int WORD_BITS_DEF      = 16;

    localparam int MODE_W  = 2;
    localparam int ROW_W   = 6;
    localparam int VALUE_W = 16;
    localparam int CNT_W   = 4;
    localparam int SUM_W   = 40;

    localparam logic [CNT_W-1:0] NUSE_RESET = CNT_W'(8);

    localparam logic [MODE_W-1:0] MODE_LOAD_FEATURE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_NEIGHBOR = 2'd1;
    localparam logic [MODE_W-1:0] MODE_COMPUTE       = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_WRITE
    } t_state;

    typedef struct packed {
        logic             in_ready;
        logic             capture;
        logic             issue;
        logic [CNT_W-1:0] slot;
        logic             load_out;
    } t_cmd;

    typedef struct packed {
        logic             in_compute;
        logic [CNT_W-1:0] used;
        logic             out_free;
    } t_status;

endpackage

@@ rtl/nwrs_in_if.sv @@
// Input item channel.
interface nwrs_in_if import nwrs_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [MODE_W-1:0]  mode;
    logic [ROW_W-1:0]   row;
    logic [ROW_W-1:0]   column;
    logic [ROW_W-1:0]   neighbor_index;
    logic [VALUE_W-1:0] value;

    modport source (output valid, mode, row, column, neighbor_index, value, input ready);
    modport sink   (input valid, mode, row, column, neighbor_index, value, output ready);
endinterface

@@ rtl/nwrs_out_if.sv @@
// Result item channel.
interface nwrs_out_if import nwrs_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic [ROW_W-1:0]        out_row;
    logic [ROW_W-1:0]        out_column;
    logic signed [SUM_W-1:0] weighted_sum;

    modport source (output valid, out_row, out_column, weighted_sum, input ready);
    modport sink   (input valid, out_row, out_column, weighted_sum, output ready);
endinterface

@@ rtl/nwrs_cfg_if.sv @@
// Configuration write channel.
interface nwrs_cfg_if import nwrs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

@@ rtl/nwrs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module nwrs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end
endmodule

@@ rtl/nwrs_ctrl.sv @@
// Controller state machine: slot sequencing, pipeline drain and result hand-off.
module nwrs_ctrl import nwrs_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);
    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_slot, n_slot;
    logic [1:0]       r_drain, n_drain;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_slot  <= '0;
            r_drain <= '0;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_drain <= n_drain;
        end
    end

    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        n_drain = r_drain;
        unique case (r_state)
            ST_IDLE: begin
                n_slot  = '0;
                n_drain = '0;
                if (i_status.in_compute) begin
                    n_state = (i_status.used == '0) ? ST_DRAIN : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                n_slot = r_slot + CNT_W'(1);
                if (r_slot == i_status.used - CNT_W'(1)) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_drain = r_drain + 2'd1;
                if (r_drain == 2'd2) begin
                    n_state = ST_WRITE;
                end
            end
            ST_WRITE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.slot = r_slot;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                o_cmd.capture  = i_status.in_compute;
            end
            ST_ISSUE: begin
                o_cmd.issue = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_WRITE: begin
                o_cmd.load_out = i_status.out_free;
            end
            default: begin
            end
        endcase
    end
endmodule

@@ rtl/nwrs_datapath.sv @@
// Datapath: stores, neighbor fetch, multiply-accumulate and result register.
module nwrs_datapath import nwrs_pkg::*; #(
    parameter int ITEM_COUNT     = ITEM_COUNT_DEF,
    parameter int NEIGHBOR_SLOTS = NEIGHBOR_SLOTS_DEF,
    parameter int WORD_BITS      = WORD_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic [MODE_W-1:0]       i_mode,
    input  logic [ROW_W-1:0]        i_row,
    input  logic [ROW_W-1:0]        i_column,
    input  logic [ROW_W-1:0]        i_neighbor_index,
    input  logic [VALUE_W-1:0]      i_value,
    input  logic                    i_cfg_valid,
    input  logic [CNT_W-1:0]        i_cfg_data,
    input  logic                    i_out_ready,
    input  t_cmd                    i_cmd,
    output t_status                 o_status,
    output logic                    o_out_valid,
    output logic [ROW_W-1:0]        o_out_row,
    output logic [ROW_W-1:0]        o_out_column,
    output logic signed [SUM_W-1:0] o_weighted_sum
);
    localparam int REACH = 1 << ROW_W;
    localparam int ROWS  = (ITEM_COUNT < REACH) ? ITEM_COUNT : REACH;
    localparam int WB    = (WORD_BITS < VALUE_W) ? WORD_BITS : VALUE_W;
    localparam int F_DEPTH = ROWS * ROWS;
    localparam int N_DEPTH = ROWS * NEIGHBOR_SLOTS;
    localparam int FA_W = $clog2(F_DEPTH);
    localparam int NA_W = $clog2(N_DEPTH);
    localparam int NB_W = ROW_W + WB;

    logic [CNT_W-1:0] r_nuse;
    logic             accept;
    logic             row_ok, col_ok, slot_ok;
    logic             f_wr, n_wr;
    logic [FA_W-1:0]  f_wr_addr, f_rd_addr;
    logic [NA_W-1:0]  n_wr_addr, n_rd_addr;
    logic [WB-1:0]    f_rd_data;
    logic [NB_W-1:0]  n_rd_data;
    logic [ROW_W-1:0] nb_idx;

    logic [ROW_W-1:0]        r_row, r_col;
    logic                    r_s1, r_s2, r_s3;
    logic signed [WB-1:0]    r_w2;
    logic signed [2*WB-1:0]  r_prod;
    logic signed [SUM_W-1:0] r_acc;
    logic                    r_out_valid;
    logic [ROW_W-1:0]        r_out_row, r_out_col;
    logic signed [SUM_W-1:0] r_out_sum;

    assign accept  = i_in_valid && i_cmd.in_ready;
    assign row_ok  = 32'(i_row) < ITEM_COUNT;
    assign col_ok  = 32'(i_column) < ITEM_COUNT;
    assign slot_ok = 32'(i_column) < NEIGHBOR_SLOTS;

    assign f_wr = accept && (i_mode == MODE_LOAD_FEATURE) && row_ok && col_ok;
    assign n_wr = accept && (i_mode == MODE_LOAD_NEIGHBOR) && row_ok && slot_ok;

    assign f_wr_addr = FA_W'(32'(i_row) * ROWS + 32'(i_column));
    assign n_wr_addr = NA_W'(32'(i_row) * NEIGHBOR_SLOTS + 32'(i_column));
    assign n_rd_addr = NA_W'(32'(r_row) * NEIGHBOR_SLOTS + 32'(i_cmd.slot));
    assign nb_idx    = n_rd_data[NB_W-1:WB];
    assign f_rd_addr = FA_W'(32'(nb_idx) * ROWS + 32'(r_col));

    nwrs_ram #(.WIDTH(WB), .DEPTH(F_DEPTH)) u_feature_ram (
        .i_clk     (i_clk),
        .i_wr_en   (f_wr),
        .i_wr_addr (f_wr_addr),
        .i_wr_data (i_value[WB-1:0]),
        .i_rd_en   (r_s1),
        .i_rd_addr (f_rd_addr),
        .o_rd_data (f_rd_data)
    );

    nwrs_ram #(.WIDTH(NB_W), .DEPTH(N_DEPTH)) u_neighbor_ram (
        .i_clk     (i_clk),
        .i_wr_en   (n_wr),
        .i_wr_addr (n_wr_addr),
        .i_wr_data ({i_neighbor_index, i_value[WB-1:0]}),
        .i_rd_en   (i_cmd.issue),
        .i_rd_addr (n_rd_addr),
        .o_rd_data (n_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nuse      <= NUSE_RESET;
            r_s1        <= 1'b0;
            r_s2        <= 1'b0;
            r_s3        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_nuse <= i_cfg_data;
            end
            r_s1 <= i_cmd.issue;
            r_s2 <= r_s1 && (32'(nb_idx) < ITEM_COUNT);
            r_s3 <= r_s2;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row <= i_row;
            r_col <= i_column;
        end
        if (r_s1) begin
            r_w2 <= n_rd_data[WB-1:0];
        end
        if (r_s2) begin
            r_prod <= (2*WB)'($signed(f_rd_data)) * (2*WB)'(r_w2);
        end
        if (i_cmd.capture) begin
            r_acc <= '0;
        end else if (r_s3) begin
            r_acc <= r_acc + SUM_W'(r_prod);
        end
        if (i_cmd.load_out) begin
            r_out_row <= r_row;
            r_out_col <= r_col;
            r_out_sum <= r_acc;
        end
    end

    always_comb begin
        o_status.in_compute = i_in_valid && (i_mode == MODE_COMPUTE) && row_ok && col_ok;
        o_status.used       = (32'(r_nuse) > NEIGHBOR_SLOTS) ? CNT_W'(NEIGHBOR_SLOTS) : r_nuse;
        o_status.out_free   = !r_out_valid || i_out_ready;
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_row      = r_out_row;
    assign o_out_column   = r_out_col;
    assign o_weighted_sum = r_out_sum;
endmodule

@@ rtl/neighbor_weighted_row_sum_unit.sv @@
// Neighbor weighted row sum unit: top level joining controller and datapath.
//
// Load items (feature word, neighbor slot) are taken while the unit is idle and
// written straight into the feature RAM or the neighbor RAM. A compute item
// fetches one neighbor slot per cycle from the neighbor RAM port; once it is
// accepted the input stays not ready while the unit fetches each of the used
// slots (used = the configured neighbor count clamped to the slot count),
// drains the fetch/multiply/accumulate pipeline and loads the result
// register, which may wait while an earlier result is still not taken. Mode
// three and out-of-range items are dropped on acceptance. The stores come up
// unwritten, there is no clearing pass, and configuration is always ready.
`include "neighbor_weighted_row_sum_unit_defines.svh"

module neighbor_weighted_row_sum_unit import nwrs_pkg::*; #(
    parameter int ITEM_COUNT     = ITEM_COUNT_DEF,
    parameter int NEIGHBOR_SLOTS = NEIGHBOR_SLOTS_DEF,
    parameter int WORD_BITS      = WORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nwrs_in_if.sink     i_item,
    nwrs_out_if.source  o_result,
    nwrs_cfg_if.sink    i_cfg
);
    t_cmd    cmd;
    t_status status;

    assign i_item.ready = cmd.in_ready;
    assign i_cfg.ready  = 1'b1;

    nwrs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    nwrs_datapath #(
        .ITEM_COUNT     (ITEM_COUNT),
        .NEIGHBOR_SLOTS (NEIGHBOR_SLOTS),
        .WORD_BITS      (WORD_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_item.valid),
        .i_mode           (i_item.mode),
        .i_row            (i_item.row),
        .i_column         (i_item.column),
        .i_neighbor_index (i_item.neighbor_index),
        .i_value          (i_item.value),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_data       (i_cfg.data),
        .i_out_ready      (o_result.ready),
        .i_cmd            (cmd),
        .o_status         (status),
        .o_out_valid      (o_result.valid),
        .o_out_row        (o_result.out_row),
        .o_out_column     (o_result.out_column),
        .o_weighted_sum   (o_result.weighted_sum)
    );

    `NWRS_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, o_result.valid, "result not presented")
    `NWRS_ASSERT_NOW(a_load_needs_room, cmd.load_out, status.out_free, "result overwritten")
    `NWRS_ASSERT_NOW(a_capture_on_accept, cmd.capture, cmd.in_ready && i_item.valid, "bad capture")
    `NWRS_ASSERT_NOW(a_no_issue_when_ready, cmd.in_ready, !cmd.issue && !cmd.load_out, "busy while ready")
endmodule
